// ----- src/lfu_pkg.sv -----
package lfu_pkg;

  localparam int PAGE_IN_W = 16;
  localparam int USED_W    = 2;
  localparam int TOTAL_W   = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_HOLD   = 3'b100
  } state_t;

  // search record flags handed from cell to cell
  typedef struct packed {
    logic active;
    logic hit;
  } search_ctl_t;

  // frame update broadcast to all cells
  typedef struct packed {
    logic en;
    logic hit;
  } upd_ctl_t;

endpackage

// ----- src/lfu_ifs.sv -----
interface lfu_req_if;
  import lfu_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PAGE_IN_W-1:0] page_number;
  logic                 last_ref;

  modport source (output valid, output page_number, output last_ref, input ready);
  modport sink   (input valid, input page_number, input last_ref, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;
  logic               valid;
  logic               ready;
  logic               was_hit;
  logic [USED_W-1:0]  frame_used;
  logic [TOTAL_W-1:0] fault_total;
  logic               sequence_done;

  modport source (output valid, output was_hit, output frame_used, output fault_total,
                  output sequence_done, input ready);
  modport sink   (input valid, input was_hit, input frame_used, input fault_total,
                  input sequence_done, output ready);
endinterface

// ----- src/lfu_cell.sv -----
module lfu_cell #(
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 16,
  parameter int IDX_W      = 2,
  parameter int INDEX      = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lfu_pkg::search_ctl_t    in_ctl,
  input  logic [PAGE_BITS-1:0]    in_page,
  input  logic [IDX_W-1:0]        in_hit_idx,
  input  logic [COUNT_BITS-1:0]   in_min_cnt,
  input  logic [IDX_W-1:0]        in_min_idx,
  output lfu_pkg::search_ctl_t    out_ctl,
  output logic [PAGE_BITS-1:0]    out_page,
  output logic [IDX_W-1:0]        out_hit_idx,
  output logic [COUNT_BITS-1:0]   out_min_cnt,
  output logic [IDX_W-1:0]        out_min_idx,
  input  lfu_pkg::upd_ctl_t       upd,
  input  logic [IDX_W-1:0]        upd_idx,
  input  logic [PAGE_BITS-1:0]    upd_page
);
  import lfu_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [PAGE_BITS-1:0]  page;
  logic                  valid;
  logic [COUNT_BITS-1:0] count;
  logic                  match;

  assign match = valid && (page == in_page);

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= '0;
    end else if (upd.en && upd_idx == MY_IDX) begin
      if (upd.hit) begin
        if (count != '1) count <= count + COUNT_BITS'(1);
      end else begin
        valid <= 1'b1;
        count <= COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && !upd.hit && upd_idx == MY_IDX) page <= upd_page;
  end

  // search hand-off to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl.active <= in_ctl.active;
      out_ctl.hit    <= in_ctl.hit || match;
    end
  end

  always_ff @(posedge clk) begin
    out_page    <= in_page;
    out_hit_idx <= (!in_ctl.hit && match) ? MY_IDX : in_hit_idx;
    if (count < in_min_cnt) begin
      out_min_cnt <= count;
      out_min_idx <= MY_IDX;
    end else begin
      out_min_cnt <= in_min_cnt;
      out_min_idx <= in_min_idx;
    end
  end

endmodule

// ----- src/lfu_page_replacement.sv -----
// Channel | Dir | Payload
// req     | in  | page_number[15:0], last_ref
// rsp     | out | was_hit, frame_used[1:0], fault_total[31:0], sequence_done
//
// One reference at a time: the search record walks the row of frame cells, one cell per
// cycle, then the result is latched in the hold state and committed onto rsp.
// A new reference is taken once the previous one commits, even while rsp is stalled.
// A result that finds rsp still full waits in a hold register until rsp frees up.
// rst (synchronous) empties all frames, zeroes use counts and the fault total.
module lfu_page_replacement #(
  parameter int NUM_FRAMES = 4,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input logic clk,
  input logic rst,
  lfu_req_if.sink   req,
  lfu_rsp_if.source rsp
);
  import lfu_pkg::*;

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  state_t                state;
  logic                  last_q;
  logic                  pend_hit;
  logic [IDX_W-1:0]      pend_idx;
  logic [PAGE_BITS-1:0]  pend_page;
  logic [TOTAL_W-1:0]    fault_counter;
  logic [TOTAL_W-1:0]    total_next;
  logic                  accept;
  logic                  commit;
  upd_ctl_t              upd;

  search_ctl_t           c_ctl   [NUM_FRAMES+1];
  logic [PAGE_BITS-1:0]  c_page  [NUM_FRAMES+1];
  logic [IDX_W-1:0]      c_hidx  [NUM_FRAMES+1];
  logic [COUNT_BITS-1:0] c_mcnt  [NUM_FRAMES+1];
  logic [IDX_W-1:0]      c_midx  [NUM_FRAMES+1];
  logic [NUM_FRAMES-1:0] active_vec;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign commit    = (state == S_HOLD) && (!rsp.valid || rsp.ready);

  assign c_ctl[0].active = accept;
  assign c_ctl[0].hit    = 1'b0;
  assign c_page[0]       = PAGE_BITS'(req.page_number);
  assign c_hidx[0]       = '0;
  assign c_mcnt[0]       = '1;
  assign c_midx[0]       = '0;

  assign upd.en  = commit;
  assign upd.hit = pend_hit;

  for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_cell
    lfu_cell #(
      .PAGE_BITS (PAGE_BITS),
      .COUNT_BITS(COUNT_BITS),
      .IDX_W     (IDX_W),
      .INDEX     (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_ctl     (c_ctl[k]),
      .in_page    (c_page[k]),
      .in_hit_idx (c_hidx[k]),
      .in_min_cnt (c_mcnt[k]),
      .in_min_idx (c_midx[k]),
      .out_ctl    (c_ctl[k+1]),
      .out_page   (c_page[k+1]),
      .out_hit_idx(c_hidx[k+1]),
      .out_min_cnt(c_mcnt[k+1]),
      .out_min_idx(c_midx[k+1]),
      .upd        (upd),
      .upd_idx    (pend_idx),
      .upd_page   (pend_page)
    );
    assign active_vec[k] = c_ctl[k+1].active;
  end

  always_comb begin
    total_next = fault_counter;
    if (!pend_hit && fault_counter != TOTAL_MAX) total_next = fault_counter + TOTAL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (accept) state <= S_SEARCH;
        S_SEARCH: if (c_ctl[NUM_FRAMES].active) state <= S_HOLD;
        S_HOLD:   if (commit) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) last_q <= req.last_ref;
    if (state == S_SEARCH && c_ctl[NUM_FRAMES].active) begin
      pend_hit  <= c_ctl[NUM_FRAMES].hit;
      pend_idx  <= c_ctl[NUM_FRAMES].hit ? c_hidx[NUM_FRAMES] : c_midx[NUM_FRAMES];
      pend_page <= c_page[NUM_FRAMES];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_counter <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      if (commit) begin
        fault_counter <= last_q ? '0 : total_next;
        rsp.valid     <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.was_hit       <= pend_hit;
      rsp.frame_used    <= USED_W'(pend_idx);
      rsp.fault_total   <= total_next;
      rsp.sequence_done <= last_q;
    end
  end

  // at most one reference walks the cell row
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0(active_vec))
    else $error("more than one search record in the cell row");

  // the record leaves the row only while the controller is searching
  a_exit_in_search: assert property (@(posedge clk) disable iff (rst)
    c_ctl[NUM_FRAMES].active |-> state == S_SEARCH)
    else $error("search record left the row outside search");

  // a fault always counts at least itself
  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.was_hit |-> rsp.fault_total != '0)
    else $error("fault reported with zero total");

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_pkg::*;

  localparam int FRAMES  = 4;
  localparam int COUNT_W = 16;
  localparam int RANDOM_REFS = 1400;
  localparam int CALM_TAIL   = 200;

  typedef struct packed {
    logic               hit;
    logic [USED_W-1:0]  frame;
    logic [TOTAL_W-1:0] total;
    logic               done;
  } lfu_result_t;

  typedef struct packed {
    logic [PAGE_IN_W-1:0] page;
    logic                 last;
    int                   reps;
    logic                 typed;
    logic                 hit;
    logic [USED_W-1:0]    frame;
    logic [TOTAL_W-1:0]   total;
  } ref_row_t;

  logic clk;
  logic rst;

  lfu_req_if req ();
  lfu_rsp_if rsp ();

  lfu_page_replacement dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  logic [PAGE_IN_W-1:0] frame_page_q [FRAMES];
  logic                 frame_valid_q[FRAMES];
  logic [COUNT_W-1:0]   use_count_q  [FRAMES];
  logic [TOTAL_W-1:0]   fault_run_q;

  lfu_result_t results_due[$];
  lfu_result_t due;

  bit gaps_on = 1'b1;
  int errors  = 0;
  int n_checked = 0;
  int n_hits    = 0;
  int n_ends    = 0;
  int stall_left = 0;

  // page, last, repeat, typed, hit, frame, total
  ref_row_t ref_plan [14] = '{
    '{16'h0000, 1'b0, 1,     1'b1, 1'b0, 2'd0, 32'd1},
    '{16'hFFFF, 1'b0, 1,     1'b1, 1'b0, 2'd1, 32'd2},
    '{16'h0000, 1'b0, 1,     1'b1, 1'b1, 2'd0, 32'd2},
    '{16'h8001, 1'b0, 1,     1'b1, 1'b0, 2'd2, 32'd3},
    '{16'h7FFE, 1'b0, 1,     1'b1, 1'b0, 2'd3, 32'd4},
    '{16'h1234, 1'b1, 1,     1'b1, 1'b0, 2'd1, 32'd5},
    '{16'h1234, 1'b0, 1,     1'b1, 1'b1, 2'd1, 32'd0},
    '{16'h0000, 1'b1, 1,     1'b1, 1'b1, 2'd0, 32'd0},
    // lift frame 0 above the rest, leave frames 1 to 3 tied
    '{16'h0000, 1'b0, 9,     1'b0, 1'b0, 2'd0, 32'd0},
    '{16'h1234, 1'b0, 8,     1'b0, 1'b0, 2'd0, 32'd0},
    '{16'h8001, 1'b0, 9,     1'b0, 1'b0, 2'd0, 32'd0},
    '{16'h7FFE, 1'b0, 9,     1'b0, 1'b0, 2'd0, 32'd0},
    '{16'h5555, 1'b0, 1,     1'b1, 1'b0, 2'd1, 32'd1},
    '{16'hAAAA, 1'b1, 1,     1'b1, 1'b0, 2'd1, 32'd2}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic lfu_result_t lfu_replace(input logic [PAGE_IN_W-1:0] pg,
                                              input logic lr);
    lfu_result_t        r;
    int                 slot;
    logic [COUNT_W-1:0] low;
    r    = '0;
    slot = -1;
    for (int k = 0; k < FRAMES; k++) begin
      if (slot < 0 && frame_valid_q[k] && frame_page_q[k] == pg) slot = k;
    end
    if (slot >= 0) begin
      r.hit = 1'b1;
      if (use_count_q[slot] != '1) use_count_q[slot] = use_count_q[slot] + 1'b1;
    end else begin
      slot = 0;
      low  = use_count_q[0];
      for (int k = 1; k < FRAMES; k++) begin
        if (use_count_q[k] < low) begin
          low  = use_count_q[k];
          slot = k;
        end
      end
      frame_page_q[slot]  = pg;
      frame_valid_q[slot] = 1'b1;
      use_count_q[slot]   = COUNT_W'(1);
      if (fault_run_q != TOTAL_MAX) fault_run_q = fault_run_q + 1'b1;
    end
    r.frame = USED_W'(slot);
    r.total = fault_run_q;
    r.done  = lr;
    if (lr) fault_run_q = '0;
    return r;
  endfunction

  task automatic send_ref(input logic [PAGE_IN_W-1:0] pg, input logic lr,
                          input logic typed, input lfu_result_t typed_res);
    lfu_result_t r;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    req.valid       <= 1'b1;
    req.page_number <= pg;
    req.last_ref    <= lr;
    do @(posedge clk); while (!req.ready);
    r = lfu_replace(pg, lr);
    results_due.push_back(typed ? typed_res : r);
  endtask

  // response side: random stall bursts
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (results_due.size() == 0) begin
        $error("result beat with nothing pending: hit=%0b frame=%0d total=%0d done=%0b",
               rsp.was_hit, rsp.frame_used, rsp.fault_total, rsp.sequence_done);
        errors++;
      end else begin
        due = results_due.pop_front();
        n_checked++;
        if (rsp.was_hit) n_hits++;
        if (rsp.sequence_done) n_ends++;
        if (rsp.was_hit !== due.hit) begin
          $error("was_hit: expected %0b, got %0b", due.hit, rsp.was_hit);
          errors++;
        end
        if (rsp.frame_used !== due.frame) begin
          $error("frame_used: expected %0d, got %0d", due.frame, rsp.frame_used);
          errors++;
        end
        if (rsp.fault_total !== due.total) begin
          $error("fault_total: expected %0d, got %0d", due.total, rsp.fault_total);
          errors++;
        end
        if (rsp.sequence_done !== due.done) begin
          $error("sequence_done: expected %0b, got %0b", due.done, rsp.sequence_done);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [PAGE_IN_W-1:0] work_set[8];
    lfu_result_t          typed_res;
    int                   sent;
    int                   seq_len;
    int                   set_size;
    bit                   noisy;
    logic                 lr;

    rst             = 1'b1;
    req.valid       = 1'b0;
    req.page_number = '0;
    req.last_ref    = 1'b0;
    for (int k = 0; k < FRAMES; k++) begin
      frame_page_q[k]  = '0;
      frame_valid_q[k] = 1'b0;
      use_count_q[k]   = '0;
    end
    fault_run_q = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (ref_plan[i]) begin
      gaps_on   = (ref_plan[i].reps == 1);
      typed_res = '{hit: ref_plan[i].hit, frame: ref_plan[i].frame,
                    total: ref_plan[i].total, done: ref_plan[i].last};
      repeat (ref_plan[i].reps)
        send_ref(ref_plan[i].page, ref_plan[i].last, ref_plan[i].typed, typed_res);
    end

    sent = 0;
    while (sent < RANDOM_REFS) begin
      seq_len  = $urandom_range(3, 40);
      set_size = $urandom_range(1, 8);
      noisy    = ($urandom_range(0, 7) == 0);
      foreach (work_set[k]) work_set[k] = PAGE_IN_W'($urandom);
      for (int j = 0; j < seq_len; j++) begin
        gaps_on = (sent < RANDOM_REFS - CALM_TAIL);
        lr = (j == seq_len - 1) || ($urandom_range(0, 40) == 0);
        send_ref(noisy ? PAGE_IN_W'($urandom) : work_set[$urandom_range(0, set_size - 1)],
                 lr, 1'b0, '0);
        sent++;
      end
    end

    @(negedge clk);
    req.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d results: %0d hits, %0d faults, %0d sequence ends",
             n_checked, n_hits, n_checked - n_hits, n_ends);
    $display("covered empty-frame fill, LFU eviction with ties, fault total clear at ends");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
